/* hw/rtl/lcal_pkg.sv */
// Shared types and constants for the lowest common ancestor lifting core.
`default_nettype none
package lcal_pkg;
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;
   localparam logic RESULT_BUILD = 1'b0;
   localparam logic RESULT_QUERY = 1'b1;
   localparam logic [9:0] ROOT_NODE = 10'd1;

   typedef struct packed {
      logic [1:0] req_type;
      logic [9:0] node_id;
      logic [9:0] parent_id;
      logic [9:0] node_depth;
      logic [9:0] node_a;
      logic [9:0] node_b;
   } req_type_type;

   typedef struct packed {
      logic       result_kind;
      logic [9:0] ancestor;
      logic       bad_query;
   } rsp_type;

   // Datapath operation selected by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_BINIT, OP_BRD1, OP_BRD2, OP_BWR,
      OP_QINIT, OP_QSWAP, OP_LIFT, OP_LIFTW, OP_CMP, OP_JRD, OP_JW, OP_FRD, OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic build_more_levels;
      logic lift_more;
      logic lift_hit;
      logic jump_more;
      logic bad;
   } status_type;
endpackage
`default_nettype wire

/* hw/rtl/lcal_datapath.sv */
// Datapath: tables, level counter, node registers and the answer register.
`default_nettype none
module lcal_datapath #(
   parameter int MAX_NODES  = 1024,
   parameter int MAX_LEVELS = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_write,
   input  wire  [9:0]            csr_data,
   input  lcal_pkg::req_type_type item,
   input  lcal_pkg::cmd_type     cmd,
   output lcal_pkg::status_type  status,
   output logic [9:0]            answer,
   output logic                  answer_bad
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int LW = $clog2(MAX_LEVELS + 1);
   localparam int TW = $clog2(MAX_NODES * MAX_LEVELS);

   logic [9:0] jump_mem [MAX_NODES*MAX_LEVELS];
   logic [9:0] depth_mem [MAX_NODES];

   logic [9:0] count_ff, deepest_ff;
   logic [LW-1:0] levels_ff, lvl_ff, lvl_in;
   logic [9:0] a_ff, a_in, b_ff, b_in, j_ff, j_in, diff_ff, diff_in, hold_ff, hold_in;
   logic [9:0] rd_ff, rd2_ff, da_ff, db_ff;
   logic [9:0] ans_ff, ans_in;
   logic bad_ff, bad_in;
   logic [TW-1:0] raddr, raddr2;
   logic [9:0] lastn;

   function automatic logic inb(input logic [9:0] n);
      return (n != 10'd0) && ({22'd0, n} < MAX_NODES);
   endfunction

   function automatic logic [TW-1:0] addr(input logic [LW-1:0] l, input logic [9:0] n);
      logic [TW-1:0] t;
      t = TW'(l) * TW'(MAX_NODES) + TW'(NW'(n));
      return t;
   endfunction

   assign lastn = ({22'd0, count_ff} > MAX_NODES - 1) ? 10'(MAX_NODES - 1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= lcal_pkg::ROOT_NODE;
         deepest_ff <= '0;
         levels_ff <= '0;
      end else begin
         if (csr_write) count_ff <= csr_data;
         if (cmd.op == lcal_pkg::OP_LOAD && item.node_depth > deepest_ff)
            deepest_ff <= item.node_depth;
         if (cmd.op == lcal_pkg::OP_BINIT) begin
            logic [LW-1:0] lv;
            lv = '0;
            for (int i = 0; i < MAX_LEVELS; i++)
               if (({22'd0, deepest_ff} >> i) != 32'd0) lv = LW'(i + 1);
            levels_ff <= lv;
         end
      end
   end

   // Read addresses: a_ff/b_ff node at level lvl by default; build and jump reads use level lvl-1.
   always_comb begin
      raddr = addr(lvl_ff, a_ff);
      raddr2 = addr(lvl_ff, b_ff);
      if (cmd.op == lcal_pkg::OP_BRD1) raddr = addr(lvl_ff - LW'(1), j_ff);
      if (cmd.op == lcal_pkg::OP_BRD2) raddr = addr(lvl_ff - LW'(1), rd_ff);
      if (cmd.op == lcal_pkg::OP_JRD) begin
         raddr = addr(lvl_ff - LW'(1), a_ff);
         raddr2 = addr(lvl_ff - LW'(1), b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lcal_pkg::OP_LOAD && inb(item.node_id)) begin
         jump_mem[addr('0, item.node_id)] <= item.parent_id;
         depth_mem[NW'(item.node_id)] <= item.node_depth;
      end else if (cmd.op == lcal_pkg::OP_BWR) begin
         jump_mem[addr(lvl_ff, j_ff)] <= inb(hold_ff) ? rd_ff : 10'd0;
      end
      rd_ff <= jump_mem[raddr];
      rd2_ff <= jump_mem[raddr2];
      da_ff <= depth_mem[NW'(item.node_a)];
      db_ff <= depth_mem[NW'(item.node_b)];
   end

   logic [9:0] ua, ub;
   assign ua = inb(a_ff) ? rd_ff : 10'd0;
   assign ub = inb(b_ff) ? rd2_ff : 10'd0;

   always_comb begin
      lvl_in = lvl_ff; a_in = a_ff; b_in = b_ff; j_in = j_ff;
      diff_in = diff_ff; hold_in = hold_ff; ans_in = ans_ff; bad_in = bad_ff;
      case (cmd.op)
         lcal_pkg::OP_BINIT: begin lvl_in = LW'(1); j_in = 10'd1; end
         lcal_pkg::OP_BRD1: ;
         lcal_pkg::OP_BRD2: hold_in = inb(j_ff) ? rd_ff : 10'd0;
         lcal_pkg::OP_BWR: begin
            if (j_ff >= lastn) begin j_in = 10'd1; lvl_in = lvl_ff + LW'(1); end
            else j_in = j_ff + 10'd1;
         end
         lcal_pkg::OP_QINIT: begin
            a_in = item.node_a; b_in = item.node_b; ans_in = '0; lvl_in = '0;
            bad_in = !inb(item.node_a) || !inb(item.node_b) ||
                     item.node_a > count_ff || item.node_b > count_ff;
         end
         lcal_pkg::OP_QSWAP: begin
            if (da_ff < db_ff) begin
               a_in = b_ff; b_in = a_ff; diff_in = db_ff - da_ff;
            end else diff_in = da_ff - db_ff;
         end
         lcal_pkg::OP_LIFTW: begin
            if (diff_ff[0]) a_in = ua;
            diff_in = diff_ff >> 1;
            lvl_in = lvl_ff + LW'(1);
         end
         lcal_pkg::OP_CMP: begin
            ans_in = a_ff; lvl_in = levels_ff;
         end
         lcal_pkg::OP_JW: begin
            if (ua != ub) begin a_in = ua; b_in = ub; end
         end
         lcal_pkg::OP_FIN: ans_in = ua;
         default: ;
      endcase
   end

   // JRD steps the level down as it reads; FRD moves to level zero for the parent read.
   always_ff @(posedge clock) begin
      if (cmd.op == lcal_pkg::OP_JRD) lvl_ff <= lvl_ff - LW'(1);
      else if (cmd.op == lcal_pkg::OP_FRD) lvl_ff <= '0;
      else lvl_ff <= lvl_in;
      a_ff <= a_in; b_ff <= b_in; j_ff <= j_in; diff_ff <= diff_in;
      hold_ff <= hold_in; ans_ff <= ans_in; bad_ff <= bad_in;
   end

   assign status.build_more_levels = (lvl_ff < levels_ff) && (lastn != 10'd0);
   assign status.lift_more = (lvl_ff < levels_ff) && (32'(lvl_ff) < MAX_LEVELS);
   assign status.lift_hit = a_ff == b_ff;
   assign status.jump_more = lvl_ff != '0;
   assign status.bad = bad_ff;
   assign answer = ans_ff;
   assign answer_bad = bad_ff;
endmodule
`default_nettype wire

/* hw/rtl/lcal_control.sv */
// Controller state machine sequencing loads, builds and queries.
`default_nettype none
module lcal_control (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [1:0]            req_kind,
   input  lcal_pkg::status_type  status,
   output lcal_pkg::cmd_type     cmd,
   output logic                  done,
   output logic                  done_kind
);
   localparam logic [3:0] S_IDLE = 4'd0, S_BUILD0 = 4'd1, S_BRD1 = 4'd2, S_BRD2 = 4'd3,
      S_BWR = 4'd4, S_QRD = 4'd5, S_QSWAP = 4'd6, S_LIFT = 4'd7, S_LIFTW = 4'd8,
      S_CMP = 4'd9, S_JRD = 4'd10, S_JW = 4'd11, S_FRD = 4'd12, S_FIN = 4'd13,
      S_BWAIT = 4'd14, S_QEND = 4'd15;
   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = lcal_pkg::OP_NONE;
      done = 1'b0; done_kind = lcal_pkg::RESULT_QUERY;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            case (req_kind)
               lcal_pkg::REQ_LOAD: cmd.op = lcal_pkg::OP_LOAD;
               lcal_pkg::REQ_BUILD: begin cmd.op = lcal_pkg::OP_BINIT; state_in = S_BUILD0; end
               lcal_pkg::REQ_QUERY: begin cmd.op = lcal_pkg::OP_QINIT; state_in = S_QRD; end
               default: ;
            endcase
         end
         S_BUILD0: state_in = status.build_more_levels ? S_BRD1 : S_BWAIT;
         S_BRD1: begin cmd.op = lcal_pkg::OP_BRD1; state_in = S_BRD2; end
         S_BRD2: begin cmd.op = lcal_pkg::OP_BRD2; state_in = S_BWR; end
         S_BWR: begin cmd.op = lcal_pkg::OP_BWR; state_in = S_BUILD0; end
         S_BWAIT: begin done = 1'b1; done_kind = lcal_pkg::RESULT_BUILD; state_in = S_IDLE; end
         S_QRD: state_in = status.bad ? S_QEND : S_QSWAP;
         S_QSWAP: begin cmd.op = lcal_pkg::OP_QSWAP; state_in = S_LIFT; end
         S_LIFT: state_in = status.lift_more ? S_LIFTW : S_CMP;
         S_LIFTW: begin cmd.op = lcal_pkg::OP_LIFTW; state_in = S_LIFT; end
         S_CMP: begin cmd.op = lcal_pkg::OP_CMP;
            state_in = status.lift_hit ? S_QEND : S_JRD; end
         S_JRD: if (status.jump_more) begin cmd.op = lcal_pkg::OP_JRD; state_in = S_JW; end
                else begin cmd.op = lcal_pkg::OP_FRD; state_in = S_FRD; end
         S_JW: begin cmd.op = lcal_pkg::OP_JW; state_in = S_JRD; end
         S_FRD: begin state_in = S_FIN; end
         S_FIN: begin cmd.op = lcal_pkg::OP_FIN; state_in = S_QEND; end
         S_QEND: begin done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/lowest_common_ancestor_lifting_core.sv */
// Top level of the lowest common ancestor binary lifting core.
// Usage: load items (req_type 0) write a node's parent and depth and give
// no result. A build item fills ancestor levels 1 to L-1, then returns
// one item with result_kind 0. A query item returns one item with
// result_kind 1; it skips the jump steps when the lifted node already
// equals the other node, and skips all lifting when an id is out of range.
// One item is worked on at a time; req_stall is high while an item is in work
// or a result waits in the output register. A result stays on the rsp_ ports
// until taken while rsp_stall is low, and the next item enters only after the
// waiting result has been taken.
// Reset clears node_count to 1, the deepest depth and the level count; table
// contents are undefined until loaded or built.
`default_nettype none
module lowest_common_ancestor_lifting_core #(
   parameter int MAX_NODES  = 1024,
   parameter int MAX_LEVELS = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  lcal_pkg::req_type_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output lcal_pkg::rsp_type     rsp_item,
   input  wire                   csr_write,
   input  wire  [9:0]            csr_node_count
);
   lcal_pkg::cmd_type cmd;
   lcal_pkg::status_type status;
   lcal_pkg::req_type_type item_ff;
   logic busy_stall, done, done_kind, accept;
   logic [9:0] answer;
   logic answer_bad;
   logic rsp_valid_ff;
   lcal_pkg::rsp_type rsp_ff;

   assign accept = req_valid && !req_stall;
   always_ff @(posedge clock) if (accept) item_ff <= req_item;

   lcal_control u_ctl (.clock, .reset, .req_valid(req_valid && !rsp_valid_ff),
      .req_stall(busy_stall), .req_kind(req_item.req_type), .status, .cmd,
      .done, .done_kind);

   lcal_datapath #(.MAX_NODES(MAX_NODES), .MAX_LEVELS(MAX_LEVELS)) u_dp (
      .clock, .reset, .csr_write, .csr_data(csr_node_count),
      .item(cmd.op == lcal_pkg::OP_LOAD || cmd.op == lcal_pkg::OP_QINIT ||
            cmd.op == lcal_pkg::OP_BINIT ? req_item : item_ff),
      .cmd, .status, .answer, .answer_bad);

   assign req_stall = busy_stall || rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (done) begin
         rsp_ff.result_kind <= done_kind;
         rsp_ff.ancestor <= (done_kind == lcal_pkg::RESULT_QUERY && !answer_bad) ? answer : '0;
         rsp_ff.bad_query <= done_kind == lcal_pkg::RESULT_QUERY && answer_bad;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !accept) else $error("item accepted while result pending");
   a_done_when_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff) else $error("result overwritten");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_query |-> rsp_ff.ancestor == '0)
      else $error("bad query with nonzero ancestor");
endmodule
`default_nettype wire
